// ===== rtl/spline_feasibility_penalty_core_assert.svh =====
// assertion macros for the spline feasibility penalty core
// both macros sample on clk and are disabled while rst_n is low
`ifndef SPLINE_FEASIBILITY_PENALTY_CORE_ASSERT_SVH
`define SPLINE_FEASIBILITY_PENALTY_CORE_ASSERT_SVH

// same-cycle implication
`define SFP_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfp assertion failed");

// next-cycle implication
`define SFP_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfp assertion failed");

`endif

// ===== rtl/sfp_pkg.sv =====
// ----------------------------------------------------------------------------
// sfp_pkg
// shared constants, command and status types and saturating helpers
// ----------------------------------------------------------------------------
`default_nettype none

package sfp_pkg;

    localparam int POINT_MODULUS = 1024;
    localparam int PIDX_W        = 10;
    localparam int IN_TDATA_W    = 96;
    localparam int OUT_TDATA_W   = 224;
    localparam int CFG_IDX_W     = 2;
    localparam int OP_W          = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_VEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ACC = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_INT = 2'd2;

    localparam logic [31:0] MAX_VEL_RST = 32'd196608;
    localparam logic [31:0] MAX_ACC_RST = 32'd131072;
    localparam logic [31:0] INV_INT_RST = 32'd655360;

    // multiply operations of the shared unit
    localparam logic [OP_W-1:0] OP_INV2 = 4'd0;
    localparam logic [OP_W-1:0] OP_INV3 = 4'd1;
    localparam logic [OP_W-1:0] OP_VM   = 4'd2;
    localparam logic [OP_W-1:0] OP_GV   = 4'd3;
    localparam logic [OP_W-1:0] OP_CV1  = 4'd4;
    localparam logic [OP_W-1:0] OP_CV   = 4'd5;
    localparam logic [OP_W-1:0] OP_AM   = 4'd6;
    localparam logic [OP_W-1:0] OP_GA   = 4'd7;
    localparam logic [OP_W-1:0] OP_CA   = 4'd8;

    // gradient slots: oldest, middle, newest point
    localparam logic [1:0] SLOT_OLD = 2'd0;
    localparam logic [1:0] SLOT_MID = 2'd1;
    localparam logic [1:0] SLOT_NEW = 2'd2;

    localparam logic [63:0] TERM_CAP = 64'h0001_0000_0000_0000;

    typedef logic signed [47:0] grad_t;
    typedef logic signed [51:0] term_t;

    typedef struct packed {
        logic            load;
        logic            mul_start;
        logic [OP_W-1:0] op;
        logic [1:0]      axis;
        logic            diff;
        logic            apply_v;
        logic            apply_a;
        logic            emit;
        logic [1:0]      emit_slot;
        logic            emit_end;
        logic            commit;
    } sfp_cmd_t;

    typedef struct packed {
        logic       mul_done;
        logic [1:0] fill;
        logic       last;
        logic       out_free;
    } sfp_status_t;

    typedef struct packed {
        logic              run_end;
        logic [63:0]       total_cost;
        grad_t             grad_z;
        grad_t             grad_y;
        grad_t             grad_x;
        logic [PIDX_W-1:0] point_index;
    } sfp_result_t;

    function automatic term_t make_term(input logic [63:0] g, input logic neg);
        logic [48:0] capped;
        logic [51:0] mag;
        capped = (g > TERM_CAP) ? TERM_CAP[48:0] : g[48:0];
        mag = {2'b00, capped, 1'b0};
        make_term = neg ? term_t'(-mag) : term_t'(mag);
    endfunction

    function automatic grad_t sat48_add(input grad_t acc, input term_t d);
        logic [52:0] s;
        s = {{5{acc[47]}}, acc} + {d[51], d};
        if (!s[52] && (s[52:47] != 6'h00))
            sat48_add = {1'b0, {47{1'b1}}};
        else if (s[52] && (s[52:47] != 6'h3f))
            sat48_add = {1'b1, {47{1'b0}}};
        else
            sat48_add = s[47:0];
    endfunction

    function automatic logic [63:0] add_sat_u64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        add_sat_u64 = s[64] ? {64{1'b1}} : s[63:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/spline_feasibility_penalty_core.sv =====
// ----------------------------------------------------------------------------
// spline_feasibility_penalty_core
// velocity and acceleration limit penalty over a stream of spline points
//
// channel   dir  beat contents
// s_axis    in   tdata: pos_x, pos_y, pos_z; tlast: final_point
// m_axis    out  tdata: point_index, grad_x..z, total_cost; tlast: run_end
// cfg       in   index 0 max_velocity, 1 max_acceleration, 2 inv_interval
//
// per point: 23 multiplies of 4 partial products each on one 32x32
// multiplier, then the result beats, which wait out any sink stall
// one point in flight; next point taken while the last result beat waits
// reset clears run state and loads the default limits and interval
// ----------------------------------------------------------------------------
`default_nettype none

module spline_feasibility_penalty_core (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    input  wire logic [sfp_pkg::IN_TDATA_W-1:0]       s_axis_tdata,  // pos_x, pos_y, pos_z
    input  wire logic                                 s_axis_tlast,
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    output logic [sfp_pkg::OUT_TDATA_W-1:0]           m_axis_tdata,  // point_index, grad_x,
                                                                     // grad_y, grad_z,
                                                                     // total_cost, zero pad
    output logic                                      m_axis_tlast,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [sfp_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [31:0]                          cfg_data
);

    import sfp_pkg::*;

    `include "spline_feasibility_penalty_core_assert.svh"

    sfp_cmd_t    cmd;
    sfp_status_t status;
    sfp_result_t res;
    logic        in_ready;

    sfp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .status   (status)
    );

    sfp_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .in_data    (s_axis_tdata),
        .in_last    (s_axis_tlast),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (res)
    );

    assign s_axis_tready = in_ready;
    assign cfg_ready     = 1'b1;
    assign m_axis_tdata  = {6'd0, res.total_cost, res.grad_z, res.grad_y, res.grad_x,
                            res.point_index};
    assign m_axis_tlast  = res.run_end;

    `SFP_ASSERT_NOW(a_cost_only_at_end, m_axis_tvalid && !m_axis_tlast, res.total_cost == 64'd0)
    `SFP_ASSERT_NEXT(a_one_point_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `SFP_ASSERT_NOW(a_emit_into_free_slot, cmd.emit, status.out_free)
    `SFP_ASSERT_NEXT(a_mul_single_issue, cmd.mul_start, !cmd.mul_start)

endmodule

`default_nettype wire

// ===== rtl/sfp_mul.sv =====
// ----------------------------------------------------------------------------
// sfp_mul
// 64x64 multiply over four 32x32 partial products, shifted and saturated
// ----------------------------------------------------------------------------
`default_nettype none

module sfp_mul (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] a,
    input  wire logic [63:0] b,
    input  wire logic        sh0,
    output logic             done,
    output logic [63:0]      result
);

    logic         busy_reg, busy_next;
    logic [2:0]   cnt_reg, cnt_next;
    logic         prod_v_reg, prod_v_next;
    logic [1:0]   pos_reg, pos_next;
    logic [63:0]  prod_reg, prod_next;
    logic [127:0] acc_reg, acc_next;
    logic         done_reg, done_next;

    logic [31:0]  a_part;
    logic [31:0]  b_part;
    logic [127:0] shifted;

    always_comb
    begin
        a_part = cnt_reg[1] ? a[63:32] : a[31:0];
        b_part = cnt_reg[0] ? b[63:32] : b[31:0];
        case (pos_reg)
            2'd1:    shifted = {32'd0, prod_reg, 32'd0};
            2'd2:    shifted = {prod_reg, 64'd0};
            default: shifted = {64'd0, prod_reg};
        endcase
    end

    always_comb
    begin
        busy_next   = busy_reg;
        cnt_next    = cnt_reg;
        prod_v_next = prod_v_reg;
        pos_next    = pos_reg;
        prod_next   = prod_reg;
        acc_next    = acc_reg;
        done_next   = 1'b0;
        if (start && !busy_reg)
        begin
            busy_next   = 1'b1;
            cnt_next    = 3'd0;
            prod_v_next = 1'b0;
            acc_next    = '0;
        end
        else if (busy_reg)
        begin
            if (prod_v_reg)
                acc_next = acc_reg + shifted;
            if (cnt_reg == 3'd4)
            begin
                busy_next   = 1'b0;
                prod_v_next = 1'b0;
                done_next   = 1'b1;
            end
            else
            begin
                prod_next   = a_part * b_part;
                pos_next    = {1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]};
                prod_v_next = 1'b1;
                cnt_next    = cnt_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            cnt_reg    <= 3'd0;
            prod_v_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            cnt_reg    <= cnt_next;
            prod_v_reg <= prod_v_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign done = done_reg;

    always_comb
    begin
        if (sh0)
            result = (acc_reg[127:64] != 64'd0) ? {64{1'b1}} : acc_reg[63:0];
        else
            result = (acc_reg[127:80] != 48'd0) ? {64{1'b1}} : acc_reg[79:16];
    end

endmodule

`default_nettype wire

// ===== rtl/sfp_datapath.sv =====
// ----------------------------------------------------------------------------
// sfp_datapath
// point history, pending gradients, cost, limits and the shared multiplier
// ----------------------------------------------------------------------------
`default_nettype none

module sfp_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire sfp_pkg::sfp_cmd_t                 cmd,
    output sfp_pkg::sfp_status_t                   status,
    input  wire logic [sfp_pkg::IN_TDATA_W-1:0]    in_data,
    input  wire logic                              in_last,
    input  wire logic                              cfg_we,
    input  wire logic [sfp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [31:0]                       cfg_data,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output sfp_pkg::sfp_result_t                   out_result
);

    import sfp_pkg::*;

    logic [31:0] maxv_reg, maxv_next;
    logic [31:0] maxa_reg, maxa_next;
    logic [31:0] inv_reg, inv_next;

    logic signed [31:0] cur_reg [3];
    logic signed [31:0] cur_next [3];
    logic signed [31:0] p0_reg [3];
    logic signed [31:0] p0_next [3];
    logic signed [31:0] p1_reg [3];
    logic signed [31:0] p1_next [3];
    grad_t g0_reg [3];
    grad_t g0_next [3];
    grad_t g1_reg [3];
    grad_t g1_next [3];
    grad_t g2_reg [3];
    grad_t g2_next [3];

    logic [63:0]       cost_reg, cost_next;
    logic [PIDX_W-1:0] count_reg, count_next;
    logic [1:0]        fill_reg, fill_next;
    logic              last_reg, last_next;

    logic [63:0] inv2_reg, inv2_next;
    logic [63:0] inv3_reg, inv3_next;
    logic [63:0] vmag_reg, vmag_next;
    logic [63:0] amag_reg, amag_next;
    logic        vneg_reg, vneg_next;
    logic        aneg_reg, aneg_next;
    logic [63:0] ev_reg, ev_next;
    logic [63:0] ea_reg, ea_next;
    logic        vhit_reg, vhit_next;
    logic        ahit_reg, ahit_next;
    logic [63:0] gv_reg, gv_next;
    logic [63:0] cv1_reg, cv1_next;
    logic [63:0] cv_reg, cv_next;
    logic [63:0] ga_reg, ga_next;
    logic [63:0] ca_reg, ca_next;

    logic        out_valid_reg, out_valid_next;
    sfp_result_t res_reg, res_next;

    logic [63:0] mul_a;
    logic [63:0] mul_b;
    logic        mul_sh0;
    logic        mul_done;
    logic [63:0] mul_res;
    logic        out_free;

    sfp_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.mul_start),
        .a      (mul_a),
        .b      (mul_b),
        .sh0    (mul_sh0),
        .done   (mul_done),
        .result (mul_res)
    );

    always_comb
    begin
        mul_a   = 64'd0;
        mul_b   = 64'd0;
        mul_sh0 = 1'b0;
        case (cmd.op)
            OP_INV2:
            begin
                mul_a = {32'd0, inv_reg};
                mul_b = {32'd0, inv_reg};
            end
            OP_INV3:
            begin
                mul_a = inv2_reg;
                mul_b = {32'd0, inv_reg};
            end
            OP_VM:
            begin
                mul_a = vmag_reg;
                mul_b = {32'd0, inv_reg};
            end
            OP_GV:
            begin
                mul_a = ev_reg;
                mul_b = inv3_reg;
            end
            OP_CV1:
            begin
                mul_a   = ev_reg;
                mul_b   = ev_reg;
                mul_sh0 = 1'b1;
            end
            OP_CV:
            begin
                mul_a = cv1_reg;
                mul_b = inv2_reg;
            end
            OP_AM:
            begin
                mul_a = amag_reg;
                mul_b = inv2_reg;
            end
            OP_GA:
            begin
                mul_a = ea_reg;
                mul_b = inv2_reg;
            end
            OP_CA:
            begin
                mul_a   = ea_reg;
                mul_b   = ea_reg;
                mul_sh0 = 1'b1;
            end
            default:
            begin
                mul_a = 64'd0;
            end
        endcase
    end

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        logic signed [32:0]  d;
        logic signed [34:0]  dd;
        term_t               tv;
        term_t               ta;
        logic [PIDX_W+1:0]   isum;

        maxv_next = maxv_reg;
        maxa_next = maxa_reg;
        inv_next  = inv_reg;
        for (int j = 0; j < 3; j++)
        begin
            cur_next[j] = cur_reg[j];
            p0_next[j]  = p0_reg[j];
            p1_next[j]  = p1_reg[j];
            g0_next[j]  = g0_reg[j];
            g1_next[j]  = g1_reg[j];
            g2_next[j]  = g2_reg[j];
        end
        cost_next      = cost_reg;
        count_next     = count_reg;
        fill_next      = fill_reg;
        last_next      = last_reg;
        inv2_next      = inv2_reg;
        inv3_next      = inv3_reg;
        vmag_next      = vmag_reg;
        amag_next      = amag_reg;
        vneg_next      = vneg_reg;
        aneg_next      = aneg_reg;
        ev_next        = ev_reg;
        ea_next        = ea_reg;
        vhit_next      = vhit_reg;
        ahit_next      = ahit_reg;
        gv_next        = gv_reg;
        cv1_next       = cv1_reg;
        cv_next        = cv_reg;
        ga_next        = ga_reg;
        ca_next        = ca_reg;
        out_valid_next = out_valid_reg;
        res_next       = res_reg;

        d    = 33'sd0;
        dd   = 35'sd0;
        tv   = make_term(gv_reg, vneg_reg);
        ta   = make_term(ga_reg, aneg_reg);
        isum = (PIDX_W+2)'(count_reg) + (PIDX_W+2)'(POINT_MODULUS - 2)
             + (PIDX_W+2)'(cmd.emit_slot);
        if (isum >= (PIDX_W+2)'(POINT_MODULUS))
            isum = isum - (PIDX_W+2)'(POINT_MODULUS);

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_MAX_VEL: maxv_next = cfg_data;
                CFG_MAX_ACC: maxa_next = cfg_data;
                CFG_INV_INT: inv_next  = cfg_data;
                default:     maxv_next = maxv_reg;
            endcase
        end

        // take the point and age the pending gradients
        if (cmd.load)
        begin
            cur_next[0] = in_data[31:0];
            cur_next[1] = in_data[63:32];
            cur_next[2] = in_data[95:64];
            last_next   = in_last;
            for (int j = 0; j < 3; j++)
            begin
                g0_next[j] = g1_reg[j];
                g1_next[j] = g2_reg[j];
                g2_next[j] = '0;
            end
        end

        if (mul_done)
        begin
            case (cmd.op)
                OP_INV2: inv2_next = mul_res;
                OP_INV3: inv3_next = mul_res;
                OP_VM:
                begin
                    vhit_next = mul_res > {32'd0, maxv_reg};
                    ev_next   = (mul_res > {32'd0, maxv_reg})
                              ? mul_res - {32'd0, maxv_reg} : 64'd0;
                end
                OP_GV:   gv_next  = mul_res;
                OP_CV1:  cv1_next = mul_res;
                OP_CV:   cv_next  = mul_res;
                OP_AM:
                begin
                    ahit_next = mul_res > {32'd0, maxa_reg};
                    ea_next   = (mul_res > {32'd0, maxa_reg})
                              ? mul_res - {32'd0, maxa_reg} : 64'd0;
                end
                OP_GA:   ga_next  = mul_res;
                OP_CA:   ca_next  = mul_res;
                default: gv_next  = gv_reg;
            endcase
        end

        if (cmd.diff)
        begin
            d  = 33'(cur_reg[cmd.axis]) - 33'(p1_reg[cmd.axis]);
            dd = 35'(cur_reg[cmd.axis]) - (35'(p1_reg[cmd.axis]) <<< 1)
               + 35'(p0_reg[cmd.axis]);
            vneg_next = d[32];
            vmag_next = d[32] ? 64'(-d) : 64'(d);
            aneg_next = dd[34];
            amag_next = dd[34] ? 64'(-dd) : 64'(dd);
        end

        if (cmd.apply_v && (fill_reg != 2'd0) && vhit_reg)
        begin
            cost_next = add_sat_u64(cost_reg, cv_reg);
            g1_next[cmd.axis] = sat48_add(g1_reg[cmd.axis], -tv);
            g2_next[cmd.axis] = sat48_add(g2_reg[cmd.axis], tv);
        end

        if (cmd.apply_a && (fill_reg == 2'd2) && ahit_reg)
        begin
            cost_next = add_sat_u64(cost_reg, ca_reg);
            g0_next[cmd.axis] = sat48_add(g0_reg[cmd.axis], ta);
            g1_next[cmd.axis] = sat48_add(g1_reg[cmd.axis], -(ta <<< 1));
            g2_next[cmd.axis] = sat48_add(g2_reg[cmd.axis], ta);
        end

        if (cmd.emit)
        begin
            out_valid_next       = 1'b1;
            res_next.point_index = isum[PIDX_W-1:0];
            res_next.run_end     = cmd.emit_end;
            res_next.total_cost  = cmd.emit_end ? cost_reg : 64'd0;
            case (cmd.emit_slot)
                SLOT_OLD:
                begin
                    res_next.grad_x = g0_reg[0];
                    res_next.grad_y = g0_reg[1];
                    res_next.grad_z = g0_reg[2];
                end
                SLOT_MID:
                begin
                    res_next.grad_x = g1_reg[0];
                    res_next.grad_y = g1_reg[1];
                    res_next.grad_z = g1_reg[2];
                end
                default:
                begin
                    res_next.grad_x = g2_reg[0];
                    res_next.grad_y = g2_reg[1];
                    res_next.grad_z = g2_reg[2];
                end
            endcase
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.commit)
        begin
            if (last_reg)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    p0_next[j] = '0;
                    p1_next[j] = '0;
                    g0_next[j] = '0;
                    g1_next[j] = '0;
                    g2_next[j] = '0;
                end
                cost_next  = 64'd0;
                count_next = '0;
                fill_next  = 2'd0;
            end
            else
            begin
                for (int j = 0; j < 3; j++)
                begin
                    p0_next[j] = p1_reg[j];
                    p1_next[j] = cur_reg[j];
                end
                if (fill_reg != 2'd2)
                    fill_next = fill_reg + 2'd1;
                count_next = (count_reg == PIDX_W'(POINT_MODULUS - 1))
                           ? '0 : count_reg + PIDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            maxv_reg <= MAX_VEL_RST;
            maxa_reg <= MAX_ACC_RST;
            inv_reg  <= INV_INT_RST;
            for (int j = 0; j < 3; j++)
            begin
                p0_reg[j] <= '0;
                p1_reg[j] <= '0;
                g0_reg[j] <= '0;
                g1_reg[j] <= '0;
                g2_reg[j] <= '0;
            end
            cost_reg      <= 64'd0;
            count_reg     <= '0;
            fill_reg      <= 2'd0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            maxv_reg <= maxv_next;
            maxa_reg <= maxa_next;
            inv_reg  <= inv_next;
            for (int j = 0; j < 3; j++)
            begin
                p0_reg[j] <= p0_next[j];
                p1_reg[j] <= p1_next[j];
                g0_reg[j] <= g0_next[j];
                g1_reg[j] <= g1_next[j];
                g2_reg[j] <= g2_next[j];
            end
            cost_reg      <= cost_next;
            count_reg     <= count_next;
            fill_reg      <= fill_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 3; j++)
            cur_reg[j] <= cur_next[j];
        inv2_reg <= inv2_next;
        inv3_reg <= inv3_next;
        vmag_reg <= vmag_next;
        amag_reg <= amag_next;
        vneg_reg <= vneg_next;
        aneg_reg <= aneg_next;
        ev_reg   <= ev_next;
        ea_reg   <= ea_next;
        vhit_reg <= vhit_next;
        ahit_reg <= ahit_next;
        gv_reg   <= gv_next;
        cv1_reg  <= cv1_next;
        cv_reg   <= cv_next;
        ga_reg   <= ga_next;
        ca_reg   <= ca_next;
        res_reg  <= res_next;
    end

    assign status.mul_done = mul_done;
    assign status.fill     = fill_reg;
    assign status.last     = last_reg;
    assign status.out_free = out_free;
    assign out_valid       = out_valid_reg;
    assign out_result      = res_reg;

endmodule

`default_nettype wire

// ===== rtl/sfp_ctrl.sv =====
// ----------------------------------------------------------------------------
// sfp_ctrl
// sequencer: multiply steps per axis, penalty updates, result beats, commit
// ----------------------------------------------------------------------------
`default_nettype none

module sfp_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    output sfp_pkg::sfp_cmd_t         cmd,
    input  wire sfp_pkg::sfp_status_t status
);

    import sfp_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_ISSUE  = 3'd1;
    localparam logic [2:0] ST_WAIT   = 3'd2;
    localparam logic [2:0] ST_EMIT   = 3'd3;
    localparam logic [2:0] ST_COMMIT = 3'd4;

    localparam logic [3:0] SQ_INV2    = 4'd0;
    localparam logic [3:0] SQ_INV3    = 4'd1;
    localparam logic [3:0] SQ_DIFF    = 4'd2;
    localparam logic [3:0] SQ_VM      = 4'd3;
    localparam logic [3:0] SQ_GV      = 4'd4;
    localparam logic [3:0] SQ_CV1     = 4'd5;
    localparam logic [3:0] SQ_CV      = 4'd6;
    localparam logic [3:0] SQ_AM      = 4'd7;
    localparam logic [3:0] SQ_GA      = 4'd8;
    localparam logic [3:0] SQ_CA      = 4'd9;
    localparam logic [3:0] SQ_APPLY_V = 4'd10;
    localparam logic [3:0] SQ_APPLY_A = 4'd11;

    logic [2:0] state_reg, state_next;
    logic [3:0] seq_reg, seq_next;
    logic [1:0] axis_reg, axis_next;
    logic [1:0] slot_reg, slot_next;

    logic       adv;
    logic [1:0] first_slot;
    logic [1:0] last_slot;

    always_comb
    begin
        if (status.fill == 2'd2)
            first_slot = SLOT_OLD;
        else if (status.fill == 2'd1)
            first_slot = SLOT_MID;
        else
            first_slot = SLOT_NEW;
        last_slot = status.last ? SLOT_NEW : SLOT_OLD;
    end

    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        adv        = 1'b0;
        state_next = state_reg;
        seq_next   = seq_reg;
        axis_next  = axis_reg;
        slot_next  = slot_reg;

        case (seq_reg)
            SQ_INV2: cmd.op = OP_INV2;
            SQ_INV3: cmd.op = OP_INV3;
            SQ_VM:   cmd.op = OP_VM;
            SQ_GV:   cmd.op = OP_GV;
            SQ_CV1:  cmd.op = OP_CV1;
            SQ_CV:   cmd.op = OP_CV;
            SQ_AM:   cmd.op = OP_AM;
            SQ_GA:   cmd.op = OP_GA;
            SQ_CA:   cmd.op = OP_CA;
            default: cmd.op = OP_INV2;
        endcase
        cmd.axis      = axis_reg;
        cmd.emit_slot = slot_reg;
        cmd.emit_end  = status.last && (slot_reg == SLOT_NEW);

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    seq_next   = SQ_INV2;
                    axis_next  = 2'd0;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                case (seq_reg)
                    SQ_DIFF:
                    begin
                        cmd.diff = 1'b1;
                        adv      = 1'b1;
                    end
                    SQ_APPLY_V:
                    begin
                        cmd.apply_v = 1'b1;
                        adv         = 1'b1;
                    end
                    SQ_APPLY_A:
                    begin
                        cmd.apply_a = 1'b1;
                        adv         = 1'b1;
                    end
                    default:
                    begin
                        cmd.mul_start = 1'b1;
                        state_next    = ST_WAIT;
                    end
                endcase
            end
            ST_WAIT:
            begin
                if (status.mul_done)
                    adv = 1'b1;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (slot_reg == last_slot)
                        state_next = ST_COMMIT;
                    else
                        slot_next = slot_reg + 2'd1;
                end
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (adv)
        begin
            state_next = ST_ISSUE;
            if (seq_reg == SQ_APPLY_A)
            begin
                if (axis_reg == 2'd2)
                begin
                    if (!status.last && (status.fill != 2'd2))
                        state_next = ST_COMMIT;
                    else
                    begin
                        slot_next  = first_slot;
                        state_next = ST_EMIT;
                    end
                end
                else
                begin
                    axis_next = axis_reg + 2'd1;
                    seq_next  = SQ_DIFF;
                end
            end
            else
            begin
                seq_next = seq_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            seq_reg   <= SQ_INV2;
            axis_reg  <= 2'd0;
            slot_reg  <= SLOT_OLD;
        end
        else
        begin
            state_reg <= state_next;
            seq_reg   <= seq_next;
            axis_reg  <= axis_next;
            slot_reg  <= slot_next;
        end
    end

endmodule

`default_nettype wire
